[hdl/sfmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmd_pkg
// Shared types and constants of the sector frame marker detector.
// ----------------------------------------------------------------------------
package sfmd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned HistD  = 4;

  localparam logic [31:0] StartSectorPat = 32'hA00B_C00D;
  localparam logic [31:0] StartBlockPat  = 32'h1BB1_1BB1;
  localparam logic [39:0] EndBlockPat    = 40'hC2_2CC0_2CC2;
  localparam logic [39:0] EndSectorPat   = 40'hD3_3DD3_3DD3;

  localparam logic [CountW-1:0] BlockLimitReset = CountW'(512);

  typedef enum logic [2:0] {
    MK_NONE         = 3'd0,
    MK_START_SECTOR = 3'd1,
    MK_START_BLOCK  = 3'd2,
    MK_END_BLOCK    = 3'd3,
    MK_END_SECTOR   = 3'd4
  } marker_e;

  typedef enum logic {
    PH_START  = 1'b0,
    PH_MIDDLE = 1'b1
  } phase_e;

  typedef struct packed {
    logic              overrun_error;
    logic              sequence_error;
    logic [CountW-1:0] bytes_in_block;
    logic              sector_active;
    logic              block_phase;
    marker_e           marker_code;
  } result_t;

endpackage

[hdl/sector_frame_marker_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_frame_marker_detector
// Detects sector and block markers in a byte stream and tracks block framing.
// ----------------------------------------------------------------------------
// One byte per beat in, one result per byte out, one byte per clock sustained
// while the output is not stalled. A byte is registered on input, then matched
// and tracked combinationally and written to the output register. Input and
// output stages advance together whenever the output register is empty or
// being drained. The block length limit resets to 512 and should be written
// only while no bytes are in flight.
module sector_frame_marker_detector import sfmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] marker_code, [3] block_phase,
                                      // [4] sector_active, [20:5] bytes_in_block,
                                      // [21] sequence_error, [22] overrun_error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_valid_q;
  result_t           out_res_q;
  logic [CountW-1:0] limit_q;
  logic              out_load_ok, advance;
  marker_e           marker;
  result_t           result;

  assign out_load_ok   = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_load_ok;
  assign s_axis_tready = !in_valid_q || out_load_ok;
  assign cfg_ready_o   = 1'b1;

  sfmd_marker_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (in_byte_q),
    .marker_o    (marker)
  );

  sfmd_block_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .marker_i  (marker),
    .limit_i   (limit_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= BlockLimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.overrun_error,
                          out_res_q.sequence_error,
                          out_res_q.bytes_in_block,
                          out_res_q.sector_active,
                          out_res_q.block_phase,
                          out_res_q.marker_code};

endmodule

[hdl/sfmd_marker_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmd_marker_match
// Byte history and priority match against the four marker patterns.
// ----------------------------------------------------------------------------
module sfmd_marker_match import sfmd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] data_byte_i,
  output marker_e          marker_o
);

  // entry 0 holds the newest previous byte
  logic [HistD-1:0][ByteW-1:0] byte_history_q, byte_history_d;
  logic [31:0]                 word4;
  logic [39:0]                 word5;

  assign word4 = {byte_history_q[2], byte_history_q[1], byte_history_q[0], data_byte_i};
  assign word5 = {byte_history_q[3], word4};

  always_comb begin
    if (word4 == StartSectorPat) begin
      marker_o = MK_START_SECTOR;
    end else if (word4 == StartBlockPat) begin
      marker_o = MK_START_BLOCK;
    end else if (word5 == EndBlockPat) begin
      marker_o = MK_END_BLOCK;
    end else if (word5 == EndSectorPat) begin
      marker_o = MK_END_SECTOR;
    end else begin
      marker_o = MK_NONE;
    end
  end

  assign byte_history_d = {byte_history_q[HistD-2:0], data_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_history_q <= '0;
    end else if (advance_i) begin
      byte_history_q <= byte_history_d;
    end
  end

endmodule

[hdl/sfmd_block_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmd_block_tracker
// Block phase, sector-active flag and byte count, driven by detected markers.
// ----------------------------------------------------------------------------
module sfmd_block_tracker import sfmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  marker_e           marker_i,
  input  logic [CountW-1:0] limit_i,
  output result_t           result_o
);

  phase_e            phase_q, phase_d;
  logic              active_q, active_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW:0]   count_inc;
  logic              seq_err, ovr_err;

  assign count_inc = {1'b0, count_q} + (CountW+1)'(1);

  always_comb begin
    phase_d  = phase_q;
    active_d = active_q;
    count_d  = count_q;
    seq_err  = 1'b0;
    ovr_err  = 1'b0;
    if (phase_q == PH_START) begin
      case (marker_i)
        MK_START_SECTOR: begin
          active_d = 1'b1;
          count_d  = '0;
        end
        MK_END_BLOCK: begin
          phase_d = PH_MIDDLE;
          count_d = '0;
        end
        MK_START_BLOCK, MK_END_SECTOR: begin
          active_d = 1'b0;
          count_d  = '0;
          seq_err  = 1'b1;
        end
        default: begin
          if (count_inc > {1'b0, limit_i}) begin
            active_d = 1'b0;
            count_d  = '0;
            ovr_err  = 1'b1;
          end else begin
            count_d = count_inc[CountW-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    result_o.marker_code    = marker_i;
    result_o.block_phase    = phase_d;
    result_o.sector_active  = active_d;
    result_o.bytes_in_block = count_d;
    result_o.sequence_error = seq_err;
    result_o.overrun_error  = ovr_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      active_q <= 1'b0;
      count_q  <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      active_q <= active_d;
      count_q  <= count_d;
    end
  end

endmodule

[tb/tb_sector_frame_marker_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_frame_marker_detector
// Stream-level check of the sector frame marker detector.
// ----------------------------------------------------------------------------
// Bytes are queued by the stimulus process and sent by a clocked driver. Every
// accepted byte runs through a marker and framing tracker kept in the bench.
// The tracker's result goes into a FIFO that the monitor checks field by field
// against each output beat. The limit register is rewritten between phases.
// The phases cover no idling, sender gaps, receiver stalls, both at once, a
// long receiver hold-off, and finally the sticky middle-block phase.
// ----------------------------------------------------------------------------
module tb_sector_frame_marker_detector;
  import sfmd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned MaxPrinted    = 40;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;    // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [23:0] m_axis_tdata;           // [2:0] marker_code, [3] block_phase,
                                       // [4] sector_active, [20:5] bytes_in_block,
                                       // [21] sequence_error, [22] overrun_error
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i     = '0;

  sector_frame_marker_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // tracker state
  logic [4:0][7:0]   seen_bytes   = '0;
  phase_e            frame_phase  = PH_START;
  logic              in_sector    = 1'b0;
  logic [CountW-1:0] block_bytes  = '0;
  logic [CountW-1:0] block_limit  = BlockLimitReset;

  // stimulus side
  logic [7:0]      byte_queue[$];
  result_t         results_due[$];
  logic [4:0][7:0] sent_bytes    = '0;
  bit              end_block_ok  = 1'b0;
  int unsigned     queued_cnt    = 0;
  int unsigned     send_gap_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_req      = 0;
  int unsigned     hold_ack      = 0;
  int unsigned     hold_left     = 0;

  bit          byte_taken   = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_idx   = 0;
  int unsigned quiet_cycles = 0;

  function automatic marker_e find_marker(input logic [4:0][7:0] h);
    if (h[3:0] == StartSectorPat) return MK_START_SECTOR;
    if (h[3:0] == StartBlockPat) return MK_START_BLOCK;
    if (h == EndBlockPat) return MK_END_BLOCK;
    if (h == EndSectorPat) return MK_END_SECTOR;
    return MK_NONE;
  endfunction

  function automatic result_t track_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    seen_bytes = {seen_bytes[3:0], b};
    r.marker_code = find_marker(seen_bytes);
    if (frame_phase == PH_START) begin
      case (r.marker_code)
        MK_START_SECTOR: begin
          in_sector   = 1'b1;
          block_bytes = '0;
        end
        MK_END_BLOCK: begin
          frame_phase = PH_MIDDLE;
          block_bytes = '0;
        end
        MK_START_BLOCK, MK_END_SECTOR: begin
          in_sector          = 1'b0;
          block_bytes        = '0;
          r.sequence_error   = 1'b1;
        end
        default: begin
          if ({1'b0, block_bytes} + 17'd1 > {1'b0, block_limit}) begin
            in_sector       = 1'b0;
            block_bytes     = '0;
            r.overrun_error = 1'b1;
          end else begin
            block_bytes = block_bytes + 1'b1;
          end
        end
      endcase
    end
    r.block_phase    = frame_phase;
    r.sector_active  = in_sector;
    r.bytes_in_block = block_bytes;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned want_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) begin
      $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $realtime, result_idx, what,
               got_v, want_v);
    end
  endtask

  // monitor, tracker and watchdog
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    bit      beat;
    byte_taken = 1'b0;
    if (rst_ni) begin
      beat = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        beat = 1'b1;
        got  = result_t'(m_axis_tdata[22:0]);
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, 0);
        end else begin
          want = results_due.pop_front();
          if (got.marker_code !== want.marker_code)
            report_mismatch("marker_code", got.marker_code, want.marker_code);
          if (got.block_phase !== want.block_phase)
            report_mismatch("block_phase", got.block_phase, want.block_phase);
          if (got.sector_active !== want.sector_active)
            report_mismatch("sector_active", got.sector_active, want.sector_active);
          if (got.bytes_in_block !== want.bytes_in_block)
            report_mismatch("bytes_in_block", got.bytes_in_block, want.bytes_in_block);
          if (got.sequence_error !== want.sequence_error)
            report_mismatch("sequence_error", got.sequence_error, want.sequence_error);
          if (got.overrun_error !== want.overrun_error)
            report_mismatch("overrun_error", got.overrun_error, want.overrun_error);
          if (m_axis_tdata[23] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata[23], 0);
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat = 1'b1;
        results_due.push_back(track_byte(s_axis_tdata));
        byte_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        beat        = 1'b1;
        block_limit = cfg_data_i;
      end
      quiet_cycles = beat ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || byte_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and on-demand hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack++;
      hold_left = HoldOffCycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // guarded bytes never complete a marker by accident
  task automatic push_byte(input logic [7:0] b, input bit guard);
    logic [4:0][7:0] h;
    h = {sent_bytes[3:0], b};
    if (guard && find_marker(h) != MK_NONE) begin
      b = b ^ 8'h01;
      h = {sent_bytes[3:0], b};
    end
    sent_bytes = h;
    byte_queue.push_back(b);
    queued_cnt++;
  endtask

  // sends the first n bytes of a marker, oldest byte first
  task automatic send_marker(input marker_e m, input int n, input bit guard);
    logic [39:0] pat;
    int          len;
    pat = '0;
    len = (m == MK_END_BLOCK || m == MK_END_SECTOR) ? 5 : 4;
    case (m)
      MK_START_SECTOR: pat = {8'h00, StartSectorPat};
      MK_START_BLOCK:  pat = {8'h00, StartBlockPat};
      MK_END_BLOCK:    pat = EndBlockPat;
      default:         pat = EndSectorPat;
    endcase
    for (int k = len - 1; k >= len - n; k--) push_byte(pat[8*k +: 8], guard);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random_sequence(input int unsigned lim);
    int unsigned pick;
    int unsigned n;
    marker_e     m;
    pick = $urandom_range(99);
    m    = marker_e'($urandom_range(4, 1));
    if (m == MK_END_BLOCK && !end_block_ok) m = MK_END_SECTOR;
    if (pick < 55) begin
      send_marker(MK_START_SECTOR, 4, 1'b0);
      if (lim > 400) n = $urandom_range(40);
      else if ($urandom_range(1) != 0) n = lim - 1 + $urandom_range(2);
      else n = $urandom_range(lim);
      send_noise(n);
      case ($urandom_range(3))
        0: send_marker(MK_START_BLOCK, 4, 1'b0);
        1: send_marker(MK_END_SECTOR, 5, 1'b0);
        default: ;
      endcase
    end else if (pick < 70) begin
      // broken marker
      m = marker_e'($urandom_range(4, 1));
      send_marker(m, $urandom_range((m == MK_END_BLOCK || m == MK_END_SECTOR) ? 4 : 3, 1),
                  1'b1);
      send_noise($urandom_range(3, 1));
    end else if (pick < 82) begin
      send_marker(m, (m == MK_END_BLOCK || m == MK_END_SECTOR) ? 5 : 4, 1'b0);
    end else begin
      send_noise($urandom_range(6, 1));
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      1:       begin send_gap_pct = 68; recv_stall_pct = 0;  end
      2:       begin send_gap_pct = 0;  recv_stall_pct = 68; end
      3:       begin send_gap_pct = 36; recv_stall_pct = 36; end
      default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  initial begin : stimulus
    int unsigned lims [8];
    int unsigned modes [8];
    int unsigned first;
    lims  = '{2, 9, 1, 40, 5, 300, 65534, 17};
    modes = '{1, 2, 3, 0, 1, 2, 0, 3};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: smallest limit, overruns, both sequence errors, overlap
    write_limit(16'd1);
    set_idling(0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_marker(MK_START_SECTOR, 4, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    send_marker(MK_START_SECTOR, 4, 1'b0);
    send_marker(MK_START_BLOCK, 4, 1'b0);
    send_marker(MK_END_SECTOR, 5, 1'b0);
    push_byte(8'h3D, 1'b0);
    push_byte(8'hD3, 1'b0);
    send_marker(MK_END_BLOCK, 2, 1'b1);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_limit(16'(lims[p]));
      set_idling(modes[p]);
      first = queued_cnt;
      while (queued_cnt - first < 210) send_random_sequence(lims[p]);
      if (p == 3) hold_req++;
    end

    // middle block phase is sticky, so it goes last
    wait_drained();
    write_limit(16'($urandom_range(65534, 1)));
    set_idling(3);
    end_block_ok = 1'b1;
    first = queued_cnt;
    send_marker(MK_END_BLOCK, 5, 1'b0);
    while (queued_cnt - first < 220) send_random_sequence(block_limit);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
